/* sv/fft256ms_pkg.sv */
// Shared constants, types and tables for the 256-point magnitude spectrum block.
// Holds the quarter-wave sine table built at elaboration and the bit-reverse helper.
// No dependencies.
`default_nettype none

package fft256ms_pkg;

  // Transform size and sample format.
  localparam int POINTS      = 256;
  localparam int STAGES      = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 4;

  localparam int IDX_W   = STAGES;
  localparam int BF_W    = STAGES - 1;
  localparam int STAGE_W = $clog2(STAGES);
  localparam int DATA_W  = 24;
  localparam int MEM_W   = 2 * DATA_W;
  localparam int TW_W    = 17;
  localparam int MAG_W   = 16;
  localparam int MODE_W  = 2;
  localparam int QUARTER = POINTS / 4;

  // Square root unit sizing: radicand is the sum of two squared 24-bit values.
  localparam int SQ_W     = 2 * DATA_W;
  localparam int SQ_STEPS = DATA_W;
  localparam int STEP_W   = $clog2(SQ_STEPS);

  // Operation codes carried by the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPUTE = 2'd1,
    MODE_READ    = 2'd2
  } mode_e;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB,
    ST_MG_RD,
    ST_MG_SQ,
    ST_MG_SUM,
    ST_MG_SQRT,
    ST_MG_WR
  } fft_state_e;

  typedef logic [15:0] sine_tab_t [QUARTER+1];

  // Quarter-wave sine in Q1.15, from a Q30 Taylor series, evaluated at elaboration.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] q;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (64'd6746518852 * 64'(k)) / 64'(POINTS);
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q = (sum + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = q[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_Q15 = build_sine();

  // Reverse the bit order of a sample index.
  function automatic logic [IDX_W-1:0] bit_reverse(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    for (int b = 0; b < IDX_W; b++) begin
      r[b] = v[IDX_W-1-b];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/fft256ms_isqrt.sv */
// Iterative rounded integer square root, one result bit per cycle.
// Depends on fft256ms_pkg for widths; the result saturates to the magnitude width.
`default_nettype none

module fft256ms_isqrt
  import fft256ms_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SQ_W-1:0]  radicand_i,
  output logic                  done_o,
  output logic [MAG_W-1:0]      root_o
);

  logic [SQ_W-1:0]   rem_q, rem_d;
  logic [SQ_W-1:0]   res_q, res_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;
  logic              done_q, done_d;

  logic [STEP_W-1:0] step_rev;
  logic [SQ_W-1:0]   bit_w;
  logic [SQ_W-1:0]   trial;
  logic [SQ_W-1:0]   rounded;

  // Current power of four and the trial subtrahend.
  assign step_rev = STEP_W'(SQ_STEPS - 1) - step_q;
  assign bit_w    = SQ_W'(1) << {step_rev, 1'b0};
  assign trial    = res_q + bit_w;

  // One digit of the root per cycle.
  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = radicand_i;
      res_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_w;
      end else begin
        res_d = res_q >> 1;
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SQ_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  // Round to nearest from the remainder, then saturate.
  assign rounded = res_q + SQ_W'(rem_q > res_q);
  assign root_o  = (rounded > SQ_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : rounded[MAG_W-1:0];
  assign done_o  = done_q;

endmodule

`default_nettype wire

/* sv/fft256_magnitude_spectrum_top.sv */
// Top level of the 256-point radix-2 FFT magnitude spectrum block.
// Depends on fft256ms_pkg and fft256ms_isqrt.
//
// Samples are loaded one per beat (mode 0) into a 256 x 48-bit working memory at
// bit-reversed positions; a compute beat (mode 1) transforms the memory in place
// and replaces each bin by |X|/256 with 4 fraction bits; a read beat (mode 2)
// returns one bin through the memory's registered read port. A compute runs
// 1024 butterflies (read, multiply, add, two write-backs over the single memory
// write port) and then 256 magnitude bins, dominated by the bit-per-cycle square
// root unit. Input is taken only while no compute runs; a waiting result does
// not block the next beat once it is being taken.
`default_nettype none

module fft256_magnitude_spectrum_top
  import fft256ms_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [MODE_W-1:0]      mode_i,
  input  wire logic [IDX_W-1:0]       index_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [MAG_W-1:0]            magnitude_o,
  output logic                        ack_o
);

  localparam logic signed [26:0] MAX24 = 27'sd8388607;
  localparam logic signed [26:0] MIN24 = -27'sd8388608;

  fft_state_e state_q, state_d;

  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [BF_W-1:0]    bf_q, bf_d;
  logic [IDX_W-1:0]   bin_q, bin_d;
  logic               spec_valid_q, spec_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               ack_q, ack_d;
  logic               in_fire;

  // Memory ports.
  logic [MEM_W-1:0] mem_q [POINTS];
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
  logic [MEM_W-1:0] rd_a_q, rd_b_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  // Butterfly addressing and twiddle.
  logic [BF_W-1:0]         half_mask;
  logic [BF_W-1:0]         bf_j;
  logic [IDX_W-1:0]        a_addr, b_addr;
  logic [BF_W-1:0]         tw_k;
  logic signed [TW_W-1:0]  tw_c, tw_s;

  // Butterfly datapath.
  logic signed [DATA_W-1:0] ar, ai, br, bi;
  logic signed [40:0] p_rc_q, p_rc_d, p_is_q, p_is_d, p_ic_q, p_ic_d, p_rs_q, p_rs_d;
  logic signed [41:0] sum_r, sum_i;
  logic signed [26:0] tr, ti;
  logic signed [27:0] s_ar, s_ai, d_br, d_bi;
  logic [MEM_W-1:0]   res_a_q, res_a_d, res_b_q, res_b_d;

  // Magnitude datapath.
  logic signed [SQ_W-1:0] sq_r_full, sq_i_full;
  logic [SQ_W-2:0]        sq_r_q, sq_i_q;
  logic [SQ_W-1:0]        radicand;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [MAG_W-1:0]       sqrt_root;

  // Half rounded away from zero after a Q15 product sum.
  function automatic logic signed [26:0] rnd_q15(input logic signed [41:0] v);
    logic signed [41:0] t;
    t = v + $signed(42'd16384) - $signed({41'd0, v[41]});
    return t[41:15];
  endfunction

  // Halve with half rounded away from zero.
  function automatic logic signed [26:0] rnd_half(input logic signed [27:0] v);
    logic signed [27:0] t;
    t = v + $signed(28'd1) - $signed({27'd0, v[27]});
    return t[27:1];
  endfunction

  function automatic logic [DATA_W-1:0] sat24(input logic signed [26:0] v);
    logic [DATA_W-1:0] r;
    if (v > MAX24) begin
      r = MAX24[DATA_W-1:0];
    end else if (v < MIN24) begin
      r = MIN24[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  assign in_fire = in_valid_i && in_ready_o;

  // Butterfly pair for the current stage and butterfly count.
  assign half_mask = (BF_W'(1) << stage_q) - BF_W'(1);
  assign bf_j      = bf_q & half_mask;
  assign a_addr    = {bf_q & ~half_mask, 1'b0} | {1'b0, bf_j};
  assign b_addr    = a_addr | (IDX_W'(1) << stage_q);
  assign tw_k      = bf_j << (STAGE_W'(STAGES - 1) - stage_q);

  // Twiddle from the quarter-wave table.
  always_comb begin
    if (tw_k <= BF_W'(QUARTER)) begin
      tw_c = $signed({1'b0, SINE_Q15[BF_W'(QUARTER) - tw_k]});
      tw_s = $signed({1'b0, SINE_Q15[tw_k]});
    end else begin
      tw_c = -$signed({1'b0, SINE_Q15[tw_k - BF_W'(QUARTER)]});
      tw_s = $signed({1'b0, SINE_Q15[BF_W'(2 * QUARTER) - tw_k]});
    end
  end

  assign ar = $signed(rd_a_q[MEM_W-1:DATA_W]);
  assign ai = $signed(rd_a_q[DATA_W-1:0]);
  assign br = $signed(rd_b_q[MEM_W-1:DATA_W]);
  assign bi = $signed(rd_b_q[DATA_W-1:0]);

  // Twiddle products, registered before the sums.
  assign p_rc_d = br * tw_c;
  assign p_is_d = bi * tw_s;
  assign p_ic_d = bi * tw_c;
  assign p_rs_d = br * tw_s;

  // Butterfly sums with rounding and saturation.
  assign sum_r   = 42'(p_rc_q) + 42'(p_is_q);
  assign sum_i   = 42'(p_ic_q) - 42'(p_rs_q);
  assign tr      = rnd_q15(sum_r);
  assign ti      = rnd_q15(sum_i);
  assign s_ar    = 28'(ar) + 28'(tr);
  assign s_ai    = 28'(ai) + 28'(ti);
  assign d_br    = 28'(ar) - 28'(tr);
  assign d_bi    = 28'(ai) - 28'(ti);
  assign res_a_d = {sat24(rnd_half(s_ar)), sat24(rnd_half(s_ai))};
  assign res_b_d = {sat24(rnd_half(d_br)), sat24(rnd_half(d_bi))};

  // Squares for the magnitude.
  assign sq_r_full = ar * ar;
  assign sq_i_full = ai * ai;
  assign radicand  = {1'b0, sq_r_q} + {1'b0, sq_i_q};

  fft256ms_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode_i == MODE_COMPUTE) begin
            state_d = ST_BF_RD;
          end else if (mode_i == MODE_READ) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_BF_RD:  state_d = ST_BF_MUL;
      ST_BF_MUL: state_d = ST_BF_ADD;
      ST_BF_ADD: state_d = ST_BF_WA;
      ST_BF_WA:  state_d = ST_BF_WB;
      ST_BF_WB: begin
        if (bf_q == '1 && stage_q == STAGE_W'(STAGES - 1)) begin
          state_d = ST_MG_RD;
        end else begin
          state_d = ST_BF_RD;
        end
      end
      ST_MG_RD:  state_d = ST_MG_SQ;
      ST_MG_SQ:  state_d = ST_MG_SUM;
      ST_MG_SUM: state_d = ST_MG_SQRT;
      ST_MG_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_MG_WR;
        end
      end
      ST_MG_WR: begin
        state_d = (bin_q == '1) ? ST_IDLE : ST_MG_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs, memory ports, counters and the result beat.
  always_comb begin
    in_ready_o   = 1'b0;
    rd_en        = 1'b0;
    rd_addr_a    = a_addr;
    rd_addr_b    = b_addr;
    mem_we       = 1'b0;
    mem_waddr    = a_addr;
    mem_wdata    = res_a_q;
    sqrt_start   = 1'b0;
    stage_d      = stage_q;
    bf_d         = bf_q;
    bin_d        = bin_q;
    spec_valid_d = spec_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mag_d        = mag_q;
    ack_d        = ack_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_fire) begin
          unique case (mode_i)
            MODE_LOAD: begin
              mem_we       = 1'b1;
              mem_waddr    = bit_reverse(index_i);
              mem_wdata    = {DATA_W'({sample_i, {FRAC_BITS{1'b0}}}), {DATA_W{1'b0}}};
              spec_valid_d = 1'b0;
              out_valid_d  = 1'b1;
              mag_d        = '0;
              ack_d        = 1'b1;
            end
            MODE_COMPUTE: begin
              stage_d = '0;
              bf_d    = '0;
              bin_d   = '0;
            end
            MODE_READ: begin
              rd_en     = 1'b1;
              rd_addr_a = index_i;
            end
            default: begin
              out_valid_d = 1'b1;
              mag_d       = '0;
              ack_d       = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        ack_d       = spec_valid_q;
        mag_d       = spec_valid_q ? rd_a_q[DATA_W+MAG_W-1:DATA_W] : '0;
      end
      ST_BF_RD: begin
        rd_en = 1'b1;
      end
      ST_BF_WA: begin
        mem_we    = 1'b1;
        mem_waddr = a_addr;
        mem_wdata = res_a_q;
      end
      ST_BF_WB: begin
        mem_we    = 1'b1;
        mem_waddr = b_addr;
        mem_wdata = res_b_q;
        bf_d      = bf_q + BF_W'(1);
        if (bf_q == '1) begin
          stage_d = stage_q + STAGE_W'(1);
        end
      end
      ST_MG_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = bin_q;
      end
      ST_MG_SUM: begin
        sqrt_start = 1'b1;
      end
      ST_MG_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bin_q;
        mem_wdata = {DATA_W'(sqrt_root), {DATA_W{1'b0}}};
        bin_d     = bin_q + IDX_W'(1);
        if (bin_q == '1) begin
          spec_valid_d = 1'b1;
          out_valid_d  = 1'b1;
          mag_d        = '0;
          ack_d        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stage_q      <= '0;
      bf_q         <= '0;
      bin_q        <= '0;
      spec_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      stage_q      <= stage_d;
      bf_q         <= bf_d;
      bin_q        <= bin_d;
      spec_valid_q <= spec_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    ack_q <= ack_d;
    if (state_q == ST_BF_MUL) begin
      p_rc_q <= p_rc_d;
      p_is_q <= p_is_d;
      p_ic_q <= p_ic_d;
      p_rs_q <= p_rs_d;
    end
    if (state_q == ST_BF_ADD) begin
      res_a_q <= res_a_d;
      res_b_q <= res_b_d;
    end
    if (state_q == ST_MG_SQ) begin
      sq_r_q <= sq_r_full[SQ_W-2:0];
      sq_i_q <= sq_i_full[SQ_W-2:0];
    end
  end

  // Working memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign ack_o       = ack_q;

  // Beats are taken only between transforms.
  a_fire_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == ST_IDLE)
    else $error("input beat taken while the sequencer is busy");

  // Memory writes come only from loads, butterfly write-back or magnitude write.
  a_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_BF_WA || state_q == ST_BF_WB || state_q == ST_MG_WR ||
                (state_q == ST_IDLE && in_fire)))
    else $error("memory write outside a write slot");

  // The root unit finishes only while the sequencer waits for it.
  a_sqrt_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_MG_SQRT)
    else $error("square root finished outside its wait state");

  // The spectrum becomes valid only at the end of the last magnitude write.
  a_valid_rise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(spec_valid_q) |-> $past(state_q) == ST_MG_WR && $past(bin_q) == '1)
    else $error("spectrum marked valid before the transform finished");

endmodule

`default_nettype wire

/* tb/fft256ms_spectrum_checker.sv */
// Checker for the 256-point FFT magnitude spectrum block: watches both channels,
// predicts every result from the accepted input beats and compares field by field.
// Depends on fft256ms_pkg for the mode codes and field widths.
`default_nettype none

module fft256ms_spectrum_checker
  import fft256ms_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [MODE_W-1:0]      mode_i,
  input  wire logic [IDX_W-1:0]       index_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  input  wire logic [MAG_W-1:0]       magnitude_i,
  input  wire logic                   ack_i,
  output int                          error_count_o,
  output int                          pending_o,
  output int                          results_seen_o,
  output int                          computes_seen_o
);

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             ack;
  } bin_result_t;

  localparam int QTR = POINTS / 4;

  // Predicted working memory, spectrum flag and twiddle table.
  longint      re_mem [POINTS];
  longint      im_mem [POINTS];
  logic        spectrum_ready;
  longint      sine_lut [QTR+1];
  bin_result_t expected_bins [$];
  int          predicted_count;

  // Q30 Taylor series sine, rounded to Q1.15 and saturated.
  function automatic longint taylor_sine_q15(int k);
    longint unsigned x, x2, acc, term, q;
    x   = (64'd6746518852 * longint'(k)) / POINTS;
    x2  = (x * x) >> 30;
    acc = x;
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    q = (acc + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return longint'(q);
  endfunction

  // Shift right with rounding of the half away from zero.
  function automatic longint shift_round(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) begin
      return 8388607;
    end
    if (v < -8388608) begin
      return -8388608;
    end
    return v;
  endfunction

  function automatic int reverse_index(int v);
    int r;
    r = 0;
    for (int b = 0; b < STAGES; b++) begin
      r = (r << 1) | ((v >> b) & 1);
    end
    return r;
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint unsigned root_round(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (v > res) begin
      res++;
    end
    return res;
  endfunction

  // In-place butterfly stages followed by the magnitude pass.
  task automatic run_transform();
    int half, stride, tk, ia, ib;
    longint c, s, br, bi, tr, ti, ar, ai;
    longint unsigned mag;
    for (int st = 0; st < STAGES; st++) begin
      half   = 1 << st;
      stride = POINTS >> (st + 1);
      for (int j = 0; j < half; j++) begin
        tk = (j * stride) & (POINTS / 2 - 1);
        if (tk <= QTR) begin
          c = sine_lut[QTR - tk];
          s = sine_lut[tk];
        end else begin
          c = -sine_lut[(tk - QTR) & (QTR * 2 - 1)];
          s = sine_lut[(POINTS / 2 - tk) & (QTR * 2 - 1)];
        end
        for (int base = j; base < POINTS; base += 2 * half) begin
          ia = base;
          ib = base + half;
          br = re_mem[ib];
          bi = im_mem[ib];
          tr = shift_round(br * c + bi * s, 15);
          ti = shift_round(bi * c - br * s, 15);
          ar = re_mem[ia];
          ai = im_mem[ia];
          re_mem[ia] = clamp24(shift_round(ar + tr, 1));
          im_mem[ia] = clamp24(shift_round(ai + ti, 1));
          re_mem[ib] = clamp24(shift_round(ar - tr, 1));
          im_mem[ib] = clamp24(shift_round(ai - ti, 1));
        end
      end
    end
    for (int k = 0; k < POINTS; k++) begin
      mag = root_round(longint'(re_mem[k] * re_mem[k] + im_mem[k] * im_mem[k]));
      if (mag > 65535) begin
        mag = 65535;
      end
      re_mem[k] = longint'(mag);
      im_mem[k] = 0;
    end
  endtask

  initial begin
    for (int k = 0; k <= QTR; k++) begin
      sine_lut[k] = taylor_sine_q15(k);
    end
    for (int k = 0; k < POINTS; k++) begin
      re_mem[k] = 0;
      im_mem[k] = 0;
    end
    spectrum_ready = 1'b0;
    predicted_count = 0;
    error_count_o = 0;
    results_seen_o = 0;
    computes_seen_o = 0;
  end

  // Outstanding predictions: every accepted input beat minus every result beat seen.
  assign pending_o = predicted_count - results_seen_o;

  // Predict the result of every accepted input beat.
  always @(posedge clk_i) begin
    bin_result_t exp_bin;
    int pos;
    if (rst_ni && in_valid_i && in_ready_i) begin
      exp_bin = '0;
      case (mode_i)
        MODE_LOAD: begin
          pos = reverse_index(int'(index_i));
          re_mem[pos] = longint'(sample_i) << 4;
          im_mem[pos] = 0;
          spectrum_ready = 1'b0;
          exp_bin.ack = 1'b1;
        end
        MODE_COMPUTE: begin
          run_transform();
          spectrum_ready = 1'b1;
          exp_bin.ack = 1'b1;
          computes_seen_o++;
        end
        MODE_READ: begin
          if (spectrum_ready) begin
            exp_bin.magnitude = re_mem[index_i][MAG_W-1:0];
            exp_bin.ack = 1'b1;
          end
        end
        default: begin
          exp_bin = '0;
        end
      endcase
      expected_bins.push_back(exp_bin);
      predicted_count++;
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    bin_result_t exp_bin;
    if (rst_ni && out_valid_i && out_ready_i) begin
      results_seen_o++;
      if (expected_bins.size() == 0) begin
        error_count_o++;
        $display("%0t: unexpected result beat magnitude=%0d ack=%0d",
                 $time, magnitude_i, ack_i);
      end else begin
        exp_bin = expected_bins.pop_front();
        if (magnitude_i !== exp_bin.magnitude) begin
          error_count_o++;
          $display("%0t: magnitude mismatch expected=%0d actual=%0d",
                   $time, exp_bin.magnitude, magnitude_i);
        end
        if (ack_i !== exp_bin.ack) begin
          error_count_o++;
          $display("%0t: ack mismatch expected=%0d actual=%0d",
                   $time, exp_bin.ack, ack_i);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_fft256_magnitude_spectrum_top.sv */
// Testbench top for the 256-point FFT magnitude spectrum block: drives load,
// compute and read beats with random gaps and stalls, and gives the verdict.
// Depends on fft256ms_pkg, the block and fft256ms_spectrum_checker.
`default_nettype none

module tb_fft256_magnitude_spectrum_top;
  import fft256ms_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1600;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [MODE_W-1:0]      mode_i;
  logic [IDX_W-1:0]       index_i;
  logic [SAMPLE_BITS-1:0] sample_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [MAG_W-1:0]       magnitude_o;
  logic                   ack_o;

  int error_count;
  int pending;
  int results_seen;
  int computes_seen;
  int items_sent;
  bit calm;
  int stall_left;

  fft256_magnitude_spectrum_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .index_i    (index_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .magnitude_o(magnitude_o),
    .ack_o      (ack_o)
  );

  fft256ms_spectrum_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .mode_i         (mode_i),
    .index_i        (index_i),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .magnitude_i    (magnitude_o),
    .ack_i          (ack_o),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .results_seen_o (results_seen),
    .computes_seen_o(computes_seen)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #16000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: after an accepted beat, outside calm phases, most often stall for a random number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) begin
        out_ready_i <= 1'b1;
      end
    end else if (out_valid_o && out_ready_i) begin
      if (!calm && $urandom_range(3, 0) != 0) begin
        stall_left  <= $urandom_range(3, 1);
        out_ready_i <= 1'b0;
      end
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Send one input beat after a random gap and wait for its handshake.
  task automatic send_beat(logic [MODE_W-1:0] mode, int idx, int smp);
    int gap;
    gap = calm ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    index_i    <= IDX_W'(idx);
    sample_i   <= SAMPLE_BITS'(smp);
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  // Sample value for one position of a frame, by pattern.
  function automatic int frame_sample(int pattern, int k);
    case (pattern)
      0: return 4095;
      1: return (k % 2 == 0) ? 4095 : 0;
      2: return (k < 128) ? 4095 : 0;
      3: return 2048 + (k % 16 < 8 ? 1500 : -1500);
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  // Load all positions with one pattern.
  task automatic load_frame(int pattern);
    for (int k = 0; k < POINTS; k++) begin
      send_beat(MODE_LOAD, k, frame_sample(pattern, k));
    end
  endtask

  task automatic read_bins(int count);
    for (int r = 0; r < count; r++) begin
      if ($urandom_range(15, 0) == 0) begin
        send_beat(MODE_UNUSED, $urandom_range(255, 0), $urandom_range(4095, 0));
      end else begin
        send_beat(MODE_READ, $urandom_range(255, 0), $urandom_range(4095, 0));
      end
    end
  endtask

  initial begin
    int choice;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    mode_i     = MODE_LOAD;
    index_i    = '0;
    sample_i   = '0;
    items_sent = 0;
    calm       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads before any compute, the unused mode, field extremes.
    send_beat(MODE_READ, 0, 0);
    send_beat(MODE_READ, 255, 4095);
    send_beat(MODE_UNUSED, 255, 4095);
    send_beat(MODE_UNUSED, 0, 0);
    send_beat(MODE_LOAD, 0, 4095);
    send_beat(MODE_LOAD, 255, 0);
    send_beat(MODE_LOAD, 1, 4095);
    send_beat(MODE_READ, 128, 0);

    // Full frame at full scale, compute, read the DC bin and a few others.
    calm = 1'b1;
    load_frame(0);
    calm = 1'b0;
    send_beat(MODE_COMPUTE, 0, 0);
    send_beat(MODE_READ, 0, 0);
    send_beat(MODE_READ, 255, 0);
    send_beat(MODE_READ, 1, 0);
    send_beat(MODE_UNUSED, 7, 100);
    // Repeated compute transforms the magnitudes left in place.
    send_beat(MODE_COMPUTE, 255, 4095);
    send_beat(MODE_READ, 0, 0);
    // A load after compute invalidates the spectrum.
    send_beat(MODE_LOAD, 3, 1234);
    send_beat(MODE_READ, 0, 0);

    // Random frames: full reloads, partial reloads, computes and read bursts.
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(4, 0) == 0);
      choice = $urandom_range(9, 0);
      if (choice < 4) begin
        load_frame($urandom_range(7, 0));
      end else if (choice < 6) begin
        repeat ($urandom_range(20, 1)) begin
          send_beat(MODE_LOAD, $urandom_range(255, 0), $urandom_range(4095, 0));
        end
        read_bins($urandom_range(3, 0));
      end else begin
        read_bins($urandom_range(10, 0));
        continue;
      end
      if (computes_seen < 12 && $urandom_range(5, 0) != 0) begin
        send_beat(MODE_COMPUTE, $urandom_range(255, 0), $urandom_range(4095, 0));
        read_bins($urandom_range(60, 20));
      end
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then allow a few more cycles.
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (50) @(posedge clk_i);

    $display("Sent %0d input beats including %0d transforms; checked %0d result beats.",
             items_sent, computes_seen, results_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/fft256ms_pkg.sv
sv/fft256ms_isqrt.sv
sv/fft256_magnitude_spectrum_top.sv
tb/fft256ms_spectrum_checker.sv
tb/tb_fft256_magnitude_spectrum_top.sv
